@@ rtl/i2cbs_pkg.sv @@
// Shared types and constants of the I2C master byte sequencer.
// No dependencies; every other file of the block imports it.
package i2cbs_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [2:0] {
    CMD_START   = 3'd0,
    CMD_RESTART = 3'd1,
    CMD_WRITE   = 3'd2,
    CMD_READ    = 3'd3,
    CMD_STOP    = 3'd4
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BUS_FREE      = 3'd0,
    CFG_START_HOLD    = 3'd1,
    CFG_RESTART_SETUP = 3'd2,
    CFG_DATA_HOLD     = 3'd3,
    CFG_CLOCK_LOW     = 3'd4,
    CFG_CLOCK_HIGH    = 3'd5,
    CFG_STOP_SETUP    = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic       ack_flag;
    logic [7:0] sampled_bits;
    logic       sampled_ack;
  } in_item_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic [7:0] hold_us;
    logic       sample_point;
    logic       last;
    logic [7:0] read_byte;
    logic       acked;
  } out_item_t;

  // Command as it travels from the front to the back.
  typedef struct packed {
    cmd_e       kind;
    logic [7:0] data_byte;
    logic       ack_flag;
    logic [7:0] sampled_bits;
    logic       sampled_ack;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0] bus_free_us;
    logic [7:0] start_hold_us;
    logic [7:0] restart_setup_us;
    logic [7:0] data_hold_us;
    logic [7:0] clock_low_us;
    logic [7:0] clock_high_us;
    logic [7:0] stop_setup_us;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    bus_free_us:      8'd5,
    start_hold_us:    8'd4,
    restart_setup_us: 8'd5,
    data_hold_us:     8'd1,
    clock_low_us:     8'd5,
    clock_high_us:    8'd4,
    stop_setup_us:    8'd4
  };

endpackage

@@ rtl/i2cbs_front.sv @@
// Front end: accepts bus commands, drops unused codes, queues the rest.
// Depends on i2cbs_pkg.
module i2cbs_front #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  i2cbs_pkg::in_item_t in_item_i,
  output logic                cmd_valid_o,
  input  logic                cmd_take_i,
  output i2cbs_pkg::cmd_item_t cmd_item_o
);
  import i2cbs_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_item_t           mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                legal;
  logic                wr_en, rd_en;

  always_comb begin
    unique case (in_item_i.cmd) inside
      CMD_START, CMD_RESTART, CMD_WRITE, CMD_READ, CMD_STOP: legal = 1'b1;
      default:                                                legal = 1'b0;
    endcase
  end

  assign full        = (count_q == CntW'(Depth));
  assign wr_en       = push && !full && legal;
  assign cmd_valid_o = (count_q != '0);
  assign rd_en       = cmd_take_i && cmd_valid_o;
  assign cmd_item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= '{
        kind:         cmd_e'(in_item_i.cmd),
        data_byte:    in_item_i.data_byte,
        ack_flag:     in_item_i.ack_flag,
        sampled_bits: in_item_i.sampled_bits,
        sampled_ack:  in_item_i.sampled_ack
      };
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (rd_en) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count_q <= count_q + 1'b1;
      end else if (rd_en && !wr_en) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/i2cbs_back.sv @@
// Back end: walks the pin segments of one command per request, one a cycle
// if the result queue has room. Uses i2cbs_pkg; holds stored SCL/SDA levels.
module i2cbs_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  i2cbs_pkg::cfg_t      cfg_i,
  input  logic                 cmd_valid_i,
  output logic                 cmd_take_o,
  input  i2cbs_pkg::cmd_item_t cmd_item_i,
  output logic                 seg_push_o,
  input  logic                 seg_full_i,
  output i2cbs_pkg::out_item_t seg_o
);
  import i2cbs_pkg::*;

  typedef enum logic [2:0] {
    P_IDLE,
    P_FIXED,
    P_HEAD,
    P_BIT,
    P_ACK,
    P_TAIL
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [1:0] cnt_q, cnt_d;
  logic [2:0] bitn_q, bitn_d;
  logic       scl_q, sda_q;
  cmd_item_t  item_q;

  logic       is_wr, is_rd, is_stop, bit_val, last_bit;
  logic       scl, sda, smp, last, emit, done;
  logic [7:0] hold, low_wr;

  assign is_wr    = (item_q.kind == CMD_WRITE);
  assign is_rd    = (item_q.kind == CMD_READ);
  assign is_stop  = (item_q.kind == CMD_STOP);
  assign bit_val  = item_q.data_byte[~bitn_q];
  assign last_bit = (bitn_q == 3'd7);
  assign low_wr   = (cfg_i.clock_low_us > cfg_i.data_hold_us) ?
                    cfg_i.clock_low_us - cfg_i.data_hold_us : 8'd0;

  // Segment decode.
  always_comb begin
    scl  = scl_q;
    sda  = sda_q;
    hold = 8'd0;
    smp  = 1'b0;
    last = 1'b0;
    unique case (phase_q)
      P_FIXED: begin
        case (cnt_q)
          2'd0: sda = !is_stop;
          2'd1: begin
            scl  = 1'b1;
            sda  = !is_stop;
            hold = is_stop ? cfg_i.stop_setup_us :
                   (item_q.kind == CMD_RESTART) ? cfg_i.restart_setup_us :
                   cfg_i.bus_free_us;
          end
          2'd2: begin
            scl  = 1'b1;
            sda  = is_stop;
            hold = is_stop ? 8'd0 : cfg_i.start_hold_us;
            last = is_stop;
          end
          default: begin
            scl  = 1'b0;
            sda  = 1'b0;
            last = 1'b1;
          end
        endcase
      end
      P_HEAD: begin
        if (is_wr) begin
          hold = cfg_i.data_hold_us;
        end else begin
          sda = 1'b1;
        end
      end
      P_BIT: begin
        if (is_wr) begin
          sda = bit_val;
          case (cnt_q)
            2'd0: hold = low_wr;
            2'd1: begin
              scl  = 1'b1;
              hold = cfg_i.clock_high_us;
            end
            default: begin
              scl  = 1'b0;
              hold = last_bit ? 8'd0 : cfg_i.data_hold_us;
              last = last_bit && !item_q.ack_flag;
            end
          endcase
        end else begin
          sda = 1'b1;
          if (cnt_q == 2'd0) begin
            scl  = 1'b1;
            hold = cfg_i.clock_high_us;
            smp  = 1'b1;
          end else begin
            scl  = 1'b0;
            hold = cfg_i.clock_low_us;
          end
        end
      end
      P_ACK: begin
        if (is_wr) begin
          sda = 1'b1;
          case (cnt_q)
            2'd0: begin
              scl  = 1'b0;
              hold = cfg_i.clock_low_us;
            end
            2'd1: begin
              scl  = 1'b1;
              hold = cfg_i.clock_high_us;
              smp  = 1'b1;
            end
            default: begin
              scl  = 1'b0;
              last = 1'b1;
            end
          endcase
        end else begin
          scl = 1'b0;
          sda = 1'b0;
        end
      end
      P_TAIL: begin
        if (cnt_q == 2'd0) begin
          scl  = 1'b1;
          hold = cfg_i.clock_high_us;
        end else begin
          scl  = 1'b0;
          hold = cfg_i.clock_low_us;
          last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign emit       = (phase_q != P_IDLE) && !seg_full_i;
  assign done       = emit && last;
  assign seg_push_o = emit;
  assign cmd_take_o = cmd_valid_i && ((phase_q == P_IDLE) || done);

  assign seg_o = '{
    scl_release:  scl,
    sda_release:  sda,
    hold_us:      hold,
    sample_point: smp,
    last:         last,
    read_byte:    (last && is_rd) ? item_q.sampled_bits : 8'd0,
    acked:        last && is_wr && item_q.ack_flag && !item_q.sampled_ack
  };

  // Sequencing.
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    bitn_d  = bitn_q;
    if (emit && !last) begin
      unique case (phase_q)
        P_HEAD: begin
          phase_d = P_BIT;
          cnt_d   = 2'd0;
          bitn_d  = 3'd0;
        end
        P_BIT: begin
          if (cnt_q != (is_wr ? 2'd2 : 2'd1)) begin
            cnt_d = cnt_q + 2'd1;
          end else if (!last_bit) begin
            cnt_d  = 2'd0;
            bitn_d = bitn_q + 3'd1;
          end else begin
            cnt_d   = 2'd0;
            phase_d = item_q.ack_flag ? P_ACK : P_TAIL;
          end
        end
        P_ACK: begin
          if (is_wr) begin
            cnt_d = cnt_q + 2'd1;
          end else begin
            cnt_d   = 2'd0;
            phase_d = P_TAIL;
          end
        end
        default: cnt_d = cnt_q + 2'd1;
      endcase
    end else if (done) begin
      phase_d = P_IDLE;
    end
    if (cmd_take_o) begin
      cnt_d   = 2'd0;
      phase_d = ((cmd_item_i.kind == CMD_WRITE) || (cmd_item_i.kind == CMD_READ)) ?
                P_HEAD : P_FIXED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      item_q <= cmd_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      cnt_q   <= 2'd0;
      bitn_q  <= 3'd0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      bitn_q  <= bitn_d;
      if (emit) begin
        scl_q <= scl;
        sda_q <= sda;
      end
    end
  end

endmodule

@@ rtl/i2cbs_seg_fifo.sv @@
// Two-entry result queue between the back end and the result port.
// Depends on i2cbs_pkg.
module i2cbs_seg_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 full_o,
  input  i2cbs_pkg::out_item_t item_i,
  output logic                 empty,
  input  logic                 pop,
  output i2cbs_pkg::out_item_t item_o
);
  import i2cbs_pkg::*;

  out_item_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       wr_en, rd_en;

  assign full_o = (count_q == 2'd2);
  assign empty  = (count_q == 2'd0);
  assign wr_en  = push_i && !full_o;
  assign rd_en  = pop && !empty;
  assign item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (rd_en) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (wr_en && !rd_en) begin
        count_q <= count_q + 2'd1;
      end else if (rd_en && !wr_en) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

@@ rtl/i2c_master_byte_sequencer_top.sv @@
// Top level of the I2C master byte sequencer: timing registers and the
// front end, back end and result queue. Depends on i2cbs_pkg.
//
// Each bus command (start, repeated start, write byte, read byte, stop) is
// pushed as one request and comes out as its run of pin segments, one result
// request per segment, popped from the result queue. The back end produces one
// segment per clock cycle while the result queue has room. Start and repeated
// start have 4 segments, stop 3, a write 25 without ACK or 28 with, a read 19
// or 20. That segment sequencer sets the rate; a command queue of CMD_DEPTH
// entries in front of it lets the next command be pushed while the current
// one runs, and the sequencer moves on to it with no gap. Unused command codes
// are accepted and dropped and never reach the back end. The user must write
// timing registers through the cfg port only while the block is idle; the
// block does not enforce it, and an index past the last register is ignored.
module i2c_master_byte_sequencer_top #(
  parameter int unsigned CMD_DEPTH = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command side
  input  logic                                push,
  output logic                                full,
  input  i2cbs_pkg::in_item_t                 in_item_i,
  // segment side
  output logic                                empty,
  input  logic                                pop,
  output i2cbs_pkg::out_item_t                out_item_o,
  // timing registers
  input  logic                                cfg_we_i,
  input  logic [i2cbs_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [i2cbs_pkg::CfgDataW-1:0]      cfg_wdata_i
);
  import i2cbs_pkg::*;

  cfg_t      cfg_q;
  logic      cmd_valid, cmd_take;
  cmd_item_t cmd_item;
  logic      seg_push, seg_full;
  out_item_t seg;

  // Timing register file; hold values between writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BUS_FREE:      cfg_q.bus_free_us      <= cfg_wdata_i;
        CFG_START_HOLD:    cfg_q.start_hold_us    <= cfg_wdata_i;
        CFG_RESTART_SETUP: cfg_q.restart_setup_us <= cfg_wdata_i;
        CFG_DATA_HOLD:     cfg_q.data_hold_us     <= cfg_wdata_i;
        CFG_CLOCK_LOW:     cfg_q.clock_low_us     <= cfg_wdata_i;
        CFG_CLOCK_HIGH:    cfg_q.clock_high_us    <= cfg_wdata_i;
        CFG_STOP_SETUP:    cfg_q.stop_setup_us    <= cfg_wdata_i;
        default: ; // drop writes past the register list
      endcase
    end
  end

  // Accept and classify commands; queue the legal ones.
  i2cbs_front #(
    .Depth (CMD_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_take_i  (cmd_take),
    .cmd_item_o  (cmd_item)
  );

  // Advance through the segments of each command.
  i2cbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_take_o  (cmd_take),
    .cmd_item_i  (cmd_item),
    .seg_push_o  (seg_push),
    .seg_full_i  (seg_full),
    .seg_o       (seg)
  );

  // Hold finished segments until popped.
  i2cbs_seg_fifo u_seg_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (seg_push),
    .full_o (seg_full),
    .item_i (seg),
    .empty  (empty),
    .pop    (pop),
    .item_o (out_item_o)
  );

endmodule

@@ test/tb_i2c_master_byte_sequencer_top.sv @@
// Self-checking testbench of the I2C master byte sequencer top level.
// Predicts the pin segments of every command and checks each popped segment.
// Depends on i2cbs_pkg and i2c_master_byte_sequencer_top.
`timescale 1ns / 1ps

module tb_i2c_master_byte_sequencer_top;
  import i2cbs_pkg::*;

  localparam int unsigned ClkHalf      = 4;
  localparam int unsigned ResetCycles  = 7;
  // Unused codes are dropped on acceptance, so once the last segment is
  // popped the block is idle; keep a short margin before touching the
  // timing registers again.
  localparam int unsigned SettleCycles = 32;
  // Slowest correct run: ~320 commands x 28 segments x the longest pop stall, x5.
  localparam int unsigned CycleLimit   = 3_000_000;
  localparam int unsigned PhaseItems   = 45;

  // Spare register index and unused command codes.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare  = 3'd7;
  localparam logic [2:0]         CmdSpareLo   = 3'd5;
  localparam logic [2:0]         CmdSpareMid  = 3'd6;
  localparam logic [2:0]         CmdSpareHi   = 3'd7;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                push        = 1'b0;
  logic                full;
  in_item_t            in_item_i   = '0;
  logic                empty;
  logic                pop         = 1'b0;
  out_item_t           out_item_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  i2c_master_byte_sequencer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #ClkHalf clk_i = ~clk_i;

  // Commands waiting to be pushed; the head is the one offered on push.
  in_item_t    cmd_backlog[$];
  // Segments predicted for accepted commands, oldest first.
  out_item_t   segment_due[$];

  // Shadow copy of the timing registers and of the stored line levels.
  cfg_t        timing   = CfgReset;
  logic        line_scl = 1'b1;
  logic        line_sda = 1'b1;

  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned cmd_goal     = 0;
  bit          send_quiet   = 1'b0;
  bit          recv_quiet   = 1'b0;
  int unsigned send_gap     = 0;
  int unsigned recv_gap     = 0;

  // Mostly back to back, sometimes a short pause, rarely a long one.
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Append one segment and move the line levels to it.
  task automatic emit_seg(input logic scl, input logic sda, input logic [7:0] hold,
                          input logic smp);
    out_item_t s;
    s              = '0;
    s.scl_release  = scl;
    s.sda_release  = sda;
    s.hold_us      = hold;
    s.sample_point = smp;
    segment_due.push_back(s);
    line_scl = scl;
    line_sda = sda;
  endtask

  // Expand one accepted command into its pin segments.
  task automatic sequence_command(input in_item_t req);
    logic [7:0]  low_hold;
    logic        b;
    logic        ack_seen;
    int          i;
    int unsigned n_prior;
    out_item_t   tail;
    n_prior  = segment_due.size();
    ack_seen = 1'b0;
    case (req.cmd)
      CMD_START, CMD_RESTART: begin
        emit_seg(line_scl, 1'b1, 8'd0, 1'b0);
        emit_seg(1'b1, 1'b1, (req.cmd == CMD_START) ? timing.bus_free_us
                                                    : timing.restart_setup_us, 1'b0);
        emit_seg(1'b1, 1'b0, timing.start_hold_us, 1'b0);
        emit_seg(1'b0, 1'b0, 8'd0, 1'b0);
      end
      CMD_WRITE: begin
        // Data setup shrinks by the hold; clamp at zero for a short clock low.
        low_hold = (timing.clock_low_us > timing.data_hold_us)
                   ? timing.clock_low_us - timing.data_hold_us : 8'd0;
        emit_seg(line_scl, line_sda, timing.data_hold_us, 1'b0);
        for (i = 7; i >= 0; i--) begin
          b = req.data_byte[i];
          emit_seg(line_scl, b, low_hold, 1'b0);
          emit_seg(1'b1, b, timing.clock_high_us, 1'b0);
          emit_seg(1'b0, b, (i > 0) ? timing.data_hold_us : 8'd0, 1'b0);
        end
        if (req.ack_flag) begin
          emit_seg(1'b0, 1'b1, timing.clock_low_us, 1'b0);
          emit_seg(1'b1, 1'b1, timing.clock_high_us, 1'b1);
          emit_seg(1'b0, 1'b1, 8'd0, 1'b0);
          ack_seen = ~req.sampled_ack;
        end
      end
      CMD_READ: begin
        emit_seg(line_scl, 1'b1, 8'd0, 1'b0);
        for (i = 0; i < 8; i++) begin
          emit_seg(1'b1, 1'b1, timing.clock_high_us, 1'b1);
          emit_seg(1'b0, 1'b1, timing.clock_low_us, 1'b0);
        end
        if (req.ack_flag) emit_seg(1'b0, 1'b0, 8'd0, 1'b0);
        emit_seg(1'b1, line_sda, timing.clock_high_us, 1'b0);
        emit_seg(1'b0, line_sda, timing.clock_low_us, 1'b0);
      end
      CMD_STOP: begin
        emit_seg(line_scl, 1'b0, 8'd0, 1'b0);
        emit_seg(1'b1, 1'b0, timing.stop_setup_us, 1'b0);
        emit_seg(1'b1, 1'b1, 8'd0, 1'b0);
      end
      default: ;
    endcase
    // Tag the final segment; unused codes produce nothing to tag.
    if (segment_due.size() != n_prior) begin
      tail           = segment_due.pop_back();
      tail.last      = 1'b1;
      tail.read_byte = (req.cmd == CMD_READ) ? req.sampled_bits : 8'd0;
      tail.acked     = ack_seen;
      segment_due.push_back(tail);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Request driver: hold a request until accepted, predict it on acceptance,
  // then pause for a random gap before the next one.
  always @(posedge clk_i) begin : drive_requests
    logic taken;
    taken = push && !full;
    if (!rst_ni) begin
      push     <= 1'b0;
      send_gap  = 0;
    end else begin
      if (taken) begin
        sequence_command(in_item_i);
        void'(cmd_backlog.pop_front());
        send_gap = pick_gap(send_quiet);
      end
      // Hold a request that has not been taken yet; otherwise pick the next.
      if (!push || taken) begin
        if (send_gap != 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          push      <= 1'b1;
          in_item_i <= cmd_backlog[0];
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Segment monitor: compare each popped segment with the oldest prediction,
  // then stall the pop side at random.
  always @(posedge clk_i) begin : check_segments
    out_item_t want;
    if (!rst_ni) begin
      pop      <= 1'b0;
      recv_gap  = 0;
    end else begin
      if (pop && !empty) begin
        if (segment_due.size() == 0) begin
          $error("segment popped with none predicted: %p", out_item_o);
          mismatch_cnt++;
        end else begin
          want = segment_due.pop_front();
          check_field("scl_release",  want.scl_release,  out_item_o.scl_release);
          check_field("sda_release",  want.sda_release,  out_item_o.sda_release);
          check_field("hold_us",      want.hold_us,      out_item_o.hold_us);
          check_field("sample_point", want.sample_point, out_item_o.sample_point);
          check_field("last",         want.last,         out_item_o.last);
          check_field("read_byte",    want.read_byte,    out_item_o.read_byte);
          check_field("acked",        want.acked,        out_item_o.acked);
        end
        recv_gap = pick_gap(recv_quiet);
      end
      if (recv_gap != 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("i2c_master_byte_sequencer_top verification failed");
      $finish;
    end
  end

  // Queue one command; count only codes the block acts on.
  task automatic add_item(input logic [2:0] cmd, input logic [7:0] data,
                          input logic ack, input logic [7:0] bits, input logic sack);
    in_item_t req;
    req.cmd          = cmd;
    req.data_byte    = data;
    req.ack_flag     = ack;
    req.sampled_bits = bits;
    req.sampled_ack  = sack;
    cmd_backlog.push_back(req);
    if (cmd <= CMD_STOP) cmd_goal++;
  endtask

  // Write every timing register in index order plus the spare index, then
  // drop the write enable. Call only while the block is idle.
  task automatic program_timing(input cfg_t t);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_BUS_FREE;
    cfg_wdata_i <= t.bus_free_us;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_START_HOLD;
    cfg_wdata_i <= t.start_hold_us;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_RESTART_SETUP;
    cfg_wdata_i <= t.restart_setup_us;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_DATA_HOLD;
    cfg_wdata_i <= t.data_hold_us;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_CLOCK_LOW;
    cfg_wdata_i <= t.clock_low_us;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_CLOCK_HIGH;
    cfg_wdata_i <= t.clock_high_us;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_STOP_SETUP;
    cfg_wdata_i <= t.stop_setup_us;
    // The spare index must leave every register untouched.
    @(posedge clk_i);
    cfg_idx_i   <= CfgIdxSpare;
    cfg_wdata_i <= 8'($urandom_range(255));
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    timing = t;
    @(negedge clk_i);
  endtask

  function automatic cfg_t rand_timing();
    cfg_t t;
    t.bus_free_us      = 8'($urandom_range(255));
    t.start_hold_us    = 8'($urandom_range(255));
    t.restart_setup_us = 8'($urandom_range(255));
    t.data_hold_us     = 8'($urandom_range(255));
    t.clock_low_us     = 8'($urandom_range(255));
    t.clock_high_us    = 8'($urandom_range(255));
    t.stop_setup_us    = 8'($urandom_range(255));
    return t;
  endfunction

  // Wait until every request went out and every segment came back, then
  // idle for a short margin.
  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || push || segment_due.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // One well-formed bus transaction with random content: start, address
  // write, a few data writes or reads with the odd repeated start, stop.
  task automatic add_transaction();
    int unsigned n;
    int unsigned k;
    int unsigned pick;
    add_item(CMD_START, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
    add_item(CMD_WRITE, 8'($urandom), 1'b1, 8'($urandom), ($urandom_range(9) < 2));
    n = $urandom_range(1, 4);
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(9);
      if (pick < 4) begin
        add_item(CMD_WRITE, 8'($urandom), ($urandom_range(9) < 8), 8'($urandom),
                 ($urandom_range(9) < 3));
      end else if (pick < 8) begin
        add_item(CMD_READ, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        add_item(CMD_RESTART, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
        add_item(CMD_WRITE, 8'($urandom), 1'b1, 8'($urandom), 1'($urandom));
      end
    end
    add_item(CMD_STOP, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // Load one timing setting, then feed transactions mixed with noise (any
  // code, any field) until enough acted-on commands are queued.
  task automatic run_phase(input cfg_t t, input bit s_quiet, input bit r_quiet);
    int unsigned goal;
    program_timing(t);
    send_quiet = s_quiet;
    recv_quiet = r_quiet;
    goal       = cmd_goal + PhaseItems;
    while (cmd_goal < goal) begin
      if ($urandom_range(99) < 80)
        add_transaction();
      else
        add_item(3'($urandom_range(7)), 8'($urandom), 1'($urandom), 8'($urandom),
                 1'($urandom));
    end
    wait_idle();
  endtask

  initial begin : stimulus
    cfg_t t;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: field extremes, every command, both ACK paths, unused codes,
    // and commands issued from the released-bus state.
    program_timing(CfgReset);
    add_item(CMD_START,   8'h00, 1'b0, 8'h00, 1'b0);
    add_item(CMD_WRITE,   8'h00, 1'b0, 8'h00, 1'b1);  // no ACK clocked: sample ignored
    add_item(CMD_WRITE,   8'hFF, 1'b1, 8'hFF, 1'b0);  // ACKed
    add_item(CMD_WRITE,   8'hA5, 1'b1, 8'h00, 1'b1);  // NACKed
    add_item(CMD_READ,    8'hFF, 1'b1, 8'h00, 1'b1);
    add_item(CMD_READ,    8'h00, 1'b0, 8'hFF, 1'b0);
    add_item(CMD_READ,    8'h3C, 1'b1, 8'h5A, 1'b0);
    add_item(CMD_RESTART, 8'hFF, 1'b1, 8'hFF, 1'b1);
    add_item(CMD_WRITE,   8'h80, 1'b1, 8'h7E, 1'b0);
    add_item(CMD_READ,    8'h01, 1'b0, 8'h01, 1'b1);
    add_item(CMD_STOP,    8'h00, 1'b0, 8'h00, 1'b0);
    add_item(CmdSpareLo,  8'h12, 1'b1, 8'h34, 1'b0);
    add_item(CMD_STOP,    8'hFF, 1'b1, 8'hFF, 1'b1);
    add_item(CmdSpareMid, 8'h00, 1'b0, 8'h00, 1'b0);
    add_item(CmdSpareHi,  8'hFF, 1'b1, 8'hFF, 1'b1);
    add_item(CMD_READ,    8'h00, 1'b1, 8'hC3, 1'b0);  // read from idle bus
    add_item(CMD_STOP,    8'h00, 1'b0, 8'h00, 1'b0);
    add_item(CMD_WRITE,   8'h55, 1'b1, 8'h00, 1'b0);  // write from idle bus
    add_item(CMD_RESTART, 8'h00, 1'b0, 8'h00, 1'b0);
    add_item(CMD_STOP,    8'h00, 1'b0, 8'h00, 1'b0);
    wait_idle();

    // All registers at zero, no idling on either side.
    run_phase('0, 1'b1, 1'b1);
    // All registers at full scale.
    run_phase('1, 1'b0, 1'b0);
    // Short clock low: write data setup clamps to zero.
    t              = rand_timing();
    t.data_hold_us = 8'($urandom_range(100, 255));
    t.clock_low_us = 8'($urandom_range(0, 99));
    run_phase(t, 1'b0, 1'b0);
    // Zero hold with the longest clock low.
    t              = rand_timing();
    t.data_hold_us = 8'd0;
    t.clock_low_us = 8'hFF;
    run_phase(t, 1'b0, 1'b1);
    run_phase(rand_timing(), 1'b1, 1'b0);
    run_phase(rand_timing(), 1'b0, 1'b0);

    if (mismatch_cnt == 0)
      $display("i2c_master_byte_sequencer_top verification clean");
    else
      $display("i2c_master_byte_sequencer_top verification failed");
    $finish;
  end

endmodule
